### design/tfar_pkg.sv
// Shared constants, codes, types and helpers for the temporal frame average ring.
// No dependencies; compile before every other design file.
`default_nettype none

package tfar_pkg;

  // Ring geometry
  localparam int FRAMES = 8;
  localparam int PIXELS = 16384;

  // Fixed field widths
  localparam int OP_W         = 2;
  localparam int PIX_W        = 14;
  localparam int PIX_VAL_W    = 8;
  localparam int CFG_FRAMES_W = 4;
  localparam int CFG_MODE_W   = 2;
  localparam int CFG_DATA_W   = 4;
  localparam int CFG_IDX_W    = 1;

  // Derived widths
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW     = $clog2(FRAMES + 1);
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ROW_W  = FRAMES * PIX_VAL_W;
  localparam int SUM_W  = PIX_VAL_W + $clog2(FRAMES);
  localparam int FRAC_W = 16;
  localparam int ACC_W  = PIX_VAL_W + FRAC_W;
  localparam int STEP_W = $clog2(FRAMES + SUM_W);
  localparam int CMP_W  = STEP_W + 1;

  localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ADD   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_READ  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAMES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = CFG_IDX_W'(1);

  // Averaging modes
  localparam logic [CFG_MODE_W-1:0] MODE_EQUAL = CFG_MODE_W'(0);
  localparam logic [CFG_MODE_W-1:0] MODE_BLEND = CFG_MODE_W'(1);
  localparam logic [CFG_MODE_W-1:0] MODE_HALVE = CFG_MODE_W'(2);

  localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = CFG_FRAMES_W'(8);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              add_en;
    logic              read_en;
    logic              clr_en;
    logic [PIX_AW-1:0] clr_addr;
    logic              slot_reset;
    logic              acc_en;
    logic              acc_first;
    logic [STEP_W-1:0] step;
    logic              div_en;
    logic              out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [NW-1:0]         n_eff;
    logic [CFG_MODE_W-1:0] mode;
    logic                  out_free;
  } dp_status_t;

  // Write slot reduced mod the slot count, restoring style, one bit per step
  function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] ws,
                                                 input logic [NW-1:0] n);
    logic [NW+SLOT_W-1:0] r;
    logic [NW+SLOT_W-1:0] d;
    r = (NW + SLOT_W)'(ws);
    for (int b = SLOT_W - 1; b >= 0; b--) begin
      d = (NW + SLOT_W)'(n) << b;
      if (r >= d) r = r - d;
    end
    return r[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/tfar_if.sv
// Valid/ready channel interfaces for the input item and the result item.
// Depends on tfar_pkg for field widths.
`default_nettype none

interface tfar_in_if;
  import tfar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [PIX_W-1:0]     pixel_index;
  logic [PIX_VAL_W-1:0] pixel_value;
  logic                 end_of_frame;

  modport source (output valid, output opcode, output pixel_index, output pixel_value,
                  output end_of_frame, input ready);
  modport sink (input valid, input opcode, input pixel_index, input pixel_value,
                input end_of_frame, output ready);
endinterface

interface tfar_out_if;
  import tfar_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     out_index;
  logic [PIX_VAL_W-1:0] average_value;

  modport source (output valid, output out_index, output average_value, input ready);
  modport sink (input valid, input out_index, input average_value, output ready);
endinterface

`default_nettype wire

### design/tfar_ctrl.sv
// Controller state machine: input handshake, clear sweep and read sequencing.
// Depends on tfar_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module tfar_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire [tfar_pkg::OP_W-1:0]   in_opcode,
  output logic                       in_ready,
  input  tfar_pkg::dp_status_t       status,
  output tfar_pkg::ctl_cmd_t         cmd
);
  import tfar_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    clr_cnt_nxt = clr_cnt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.clr_addr = clr_cnt_r;
    cmd.step     = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (32'(clr_cnt_r) == PIXELS - 1) begin
          clr_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_ADD: cmd.add_en = 1'b1;
            OP_READ: begin
              cmd.read_en = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = ST_ACCUM;
            end
            OP_CLEAR: begin
              cmd.slot_reset = 1'b1;
              clr_cnt_nxt    = '0;
              state_nxt      = ST_CLEAR;
            end
            default: ;  // unused opcode: drop the beat
          endcase
        end
      end
      ST_ACCUM: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (cnt_r == '0);
        if (CMP_W'(cnt_r) + CMP_W'(1) == CMP_W'(status.n_eff)) begin
          cnt_nxt   = '0;
          state_nxt = (status.mode == MODE_EQUAL) ? ST_DIV : ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (32'(cnt_r) == SUM_W - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/tfar_dpath.sv
// Datapath: frame store, write slot, registers, accumulator, divider, rounding
// and the result register. Depends on tfar_pkg; commanded by tfar_ctrl.
`default_nettype none

module tfar_dpath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [tfar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tfar_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire [tfar_pkg::PIX_W-1:0]        pixel_index,
  input  wire [tfar_pkg::PIX_VAL_W-1:0]    pixel_value,
  input  wire                              end_of_frame,
  input  tfar_pkg::ctl_cmd_t               cmd,
  output tfar_pkg::dp_status_t             status,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tfar_pkg::PIX_W-1:0]       out_index,
  output logic [tfar_pkg::PIX_VAL_W-1:0]   average_value
);
  import tfar_pkg::*;

  // One row per pixel position, one byte lane per ring slot
  logic [ROW_W-1:0] mem [PIXELS];

  logic [CFG_FRAMES_W-1:0] fiu_r;
  logic [CFG_MODE_W-1:0]   mode_r;
  logic [SLOT_W-1:0]       ws_r;
  logic [ROW_W-1:0]        row_r;
  logic [PIX_W-1:0]        idx_r;
  logic                    in_range_r;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [NW-1:0]           rem_r, rem_nxt;
  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_index_r;
  logic [PIX_VAL_W-1:0]    avg_r;

  logic [NW-1:0]           n_eff;
  logic [CFG_MODE_W-1:0]   mode_eff;
  logic [SLOT_W-1:0]       s_cur, s_up, start_slot, slot_sel;
  logic                    in_range;
  logic [PIX_AW-1:0]       addr;
  logic [PIX_VAL_W-1:0]    pix;
  logic [ACC_W-1:0]        pix_fx;
  logic [ACC_W:0]          blend_sum;
  logic [CMP_W-1:0]        shamt;
  logic [NW:0]             div_t;
  logic [PIX_VAL_W-1:0]    base;
  logic                    round_up;
  logic [NW:0]             rem2;
  logic [PIX_VAL_W:0]      rounded;
  logic [PIX_VAL_W-1:0]    avg_sat;

  // Slot count and mode as used; out-of-range register values fold in
  always_comb begin
    if (fiu_r == '0) n_eff = NW'(1);
    else if (32'(fiu_r) > FRAMES) n_eff = NW'(FRAMES);
    else n_eff = NW'(fiu_r);
    if (mode_r inside {MODE_BLEND, MODE_HALVE}) mode_eff = mode_r;
    else mode_eff = MODE_EQUAL;
  end

  assign s_cur    = slot_mod(ws_r, n_eff);
  assign s_up     = (NW'(s_cur) + NW'(1) == n_eff) ? '0 : s_cur + 1'b1;
  assign in_range = 32'(pixel_index) < PIXELS;
  assign addr     = PIX_AW'(pixel_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r  <= FRAMES_RESET;
      mode_r <= MODE_EQUAL;
      ws_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_FRAMES: fiu_r  <= cfg_data[CFG_FRAMES_W-1:0];
          CFG_IDX_MODE:   mode_r <= cfg_data[CFG_MODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.slot_reset) ws_r <= '0;
      else if (cmd.add_en && end_of_frame) ws_r <= s_up;
    end
  end

  // Frame store: one write port (pixel lane or whole-row clear), one read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[cmd.clr_addr] <= '0;
    else if (cmd.add_en && in_range) mem[addr][PIX_VAL_W*s_cur +: PIX_VAL_W] <= pixel_value;
    if (cmd.read_en) row_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      idx_r      <= pixel_index;
      in_range_r <= in_range;
    end
  end

  // Walk the slots: up from 0 (equal), up from the oldest (blend), down from newest
  always_comb begin
    case (mode_eff)
      MODE_BLEND: start_slot = s_cur;
      MODE_HALVE: start_slot = (s_cur == '0) ? SLOT_W'(n_eff - 1'b1) : s_cur - 1'b1;
      default:    start_slot = '0;
    endcase
    slot_sel = cmd.acc_first ? start_slot : slot_r;
    if (mode_eff == MODE_HALVE)
      slot_nxt = (slot_sel == '0) ? SLOT_W'(n_eff - 1'b1) : slot_sel - 1'b1;
    else
      slot_nxt = (NW'(slot_sel) + NW'(1) == n_eff) ? '0 : slot_sel + 1'b1;
  end

  assign pix       = row_r[PIX_VAL_W*slot_sel +: PIX_VAL_W];
  assign pix_fx    = ACC_W'(pix) << FRAC_W;
  assign blend_sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(pix_fx);
  assign shamt     = CMP_W'(cmd.step) + CMP_W'(1);
  assign div_t     = {rem_r, acc_r[SUM_W-1]};

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    if (cmd.acc_en) begin
      if (cmd.acc_first) rem_nxt = '0;
      case (mode_eff)
        MODE_BLEND: acc_nxt = cmd.acc_first ? pix_fx : blend_sum[ACC_W:1];
        MODE_HALVE: acc_nxt = (cmd.acc_first ? '0 : acc_r) + (pix_fx >> shamt);
        default:    acc_nxt = (cmd.acc_first ? '0 : acc_r) + ACC_W'(pix);
      endcase
    end else if (cmd.div_en) begin
      // Restoring step: the sum shifts out the top as quotient bits shift in
      if (div_t >= (NW + 1)'(n_eff)) begin
        rem_nxt = NW'(div_t - (NW + 1)'(n_eff));
        acc_nxt = ACC_W'({acc_r[SUM_W-2:0], 1'b1});
      end else begin
        rem_nxt = div_t[NW-1:0];
        acc_nxt = ACC_W'({acc_r[SUM_W-2:0], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    if (cmd.acc_en) slot_r <= slot_nxt;
  end

  // Round half to even, then saturate
  always_comb begin
    rem2 = {rem_r, 1'b0};
    if (mode_eff == MODE_EQUAL) begin
      base     = acc_r[PIX_VAL_W-1:0];
      round_up = (rem2 > (NW + 1)'(n_eff)) || ((rem2 == (NW + 1)'(n_eff)) && base[0]);
    end else begin
      base     = acc_r[ACC_W-1:FRAC_W];
      round_up = (acc_r[FRAC_W-1:0] > HALF) || ((acc_r[FRAC_W-1:0] == HALF) && base[0]);
    end
    rounded = (PIX_VAL_W + 1)'(base) + (PIX_VAL_W + 1)'(round_up);
    avg_sat = rounded[PIX_VAL_W] ? '1 : rounded[PIX_VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= idx_r;
      avg_r       <= in_range_r ? avg_sat : '0;
    end
  end

  assign status.n_eff    = n_eff;
  assign status.mode     = mode_eff;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign average_value = avg_r;

endmodule

`default_nettype wire

### design/temporal_frame_average_ring.sv
// Top level of the temporal frame average ring: ties controller and datapath
// to the channels. Depends on tfar_pkg, tfar_if, tfar_ctrl and tfar_dpath.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------------
//   in_ch    | in  | valid / ready | opcode, pixel_index, pixel_value, end_of_frame
//   out_ch   | out | valid / ready | out_index, average_value
//   cfg_*    | in  | cfg_we only   | cfg_index, cfg_data (frames_in_use, average_mode)
//
// An add or an unused opcode is done when it is accepted. A read passes through the
// accept, the slot walk over one stored row, the bit-serial divider in equal mode only,
// and the load of the result register.
// Reset and every clear beat start a sweep of the frame store, one row a cycle, over all
// PIXELS (16384) rows with in_ch.ready low; configuration writes are still taken.
// The result register holds a finished beat while the next input beat is taken;
// a read that completes behind a stalled result waits until it drains.
`default_nettype none

module temporal_frame_average_ring (
  input  wire                              clk,
  input  wire                              rst_n,
  tfar_in_if.sink                          in_ch,
  tfar_out_if.source                       out_ch,
  input  wire                              cfg_we,
  input  wire [tfar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tfar_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tfar_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequence the beats: accept, sweep, walk slots, divide, load result
  tfar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the store, registers and arithmetic
  tfar_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_index   (in_ch.pixel_index),
    .pixel_value   (in_ch.pixel_value),
    .end_of_frame  (in_ch.end_of_frame),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_index     (out_ch.out_index),
    .average_value (out_ch.average_value)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

### design/tfar_checker.sv
// Port-level checks on the temporal frame average ring, bound to the top level.
// Depends on tfar_pkg for opcode names.
`default_nettype none

module tfar_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire [tfar_pkg::OP_W-1:0] in_opcode,
  input wire                      out_valid,
  input wire                      out_ready
);
  import tfar_pkg::*;

  // A pending result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Reset starts the store sweep, so input is closed right after it
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // A clear beat closes input for the sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_CLEAR |=> !in_ready)
    else $error("input open right after a clear beat");

  // A read beat closes input while the slots are walked
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_READ |=> !in_ready)
    else $error("input open right after a read beat");

  // A new result only appears at the end of a read, with input closed
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat appeared while input was open");

endmodule

bind temporal_frame_average_ring tfar_checker u_tfar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

### bench/tb_temporal_frame_average_ring.sv
// Self-checking bench for temporal_frame_average_ring: directed corner beats, then random
// frame and read bursts over eight register settings and four idling styles.
// Depends on tfar_pkg, tfar_if and the design sources of the block.
`default_nettype none

module tb_temporal_frame_average_ring;
  import tfar_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int HOT_N      = 8;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 205;
  // Spans the longest read with room to spare, so a trailing add or read is surely done.
  localparam int SETTLE_CYCLES = 2 * (FRAMES + SUM_W + 2);
  localparam logic [OP_W-1:0]       OP_UNUSED   = OP_W'(3);
  localparam logic [CFG_MODE_W-1:0] MODE_UNUSED = CFG_MODE_W'(3);

  // Tracks the ring contents and registers, and holds the averages still owed by the block.
  class ring_average_tracker;
    typedef struct packed {
      logic [PIX_W-1:0]     out_index;
      logic [PIX_VAL_W-1:0] average_value;
    } average_t;

    bit [PIX_VAL_W-1:0]    pixels [FRAMES*PIXELS];
    bit [SLOT_W-1:0]       write_slot;
    bit [CFG_FRAMES_W-1:0] frames_reg;
    bit [CFG_MODE_W-1:0]   mode_reg;
    average_t              pending_averages [$];
    int unsigned           mismatches, averages_checked, adds, clears, unused_beats, reg_writes;

    function new();
      frames_reg = FRAMES_RESET;
      mode_reg   = MODE_EQUAL;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_FRAMES) frames_reg = data[CFG_FRAMES_W-1:0];
      else mode_reg = data[CFG_MODE_W-1:0];
      reg_writes++;
    endfunction

    // Zero acts as one slot, anything above the ring size as the ring size.
    function int unsigned slots_in_use();
      if (frames_reg == 0) return 1;
      if (frames_reg > FRAMES) return FRAMES;
      return frames_reg;
    endfunction

    function logic [31:0] stored(int unsigned slot, logic [PIX_W-1:0] pix);
      return 32'(pixels[slot*PIXELS + pix]);
    endfunction

    function logic [PIX_VAL_W-1:0] weighted_average(logic [PIX_W-1:0] pix);
      int unsigned n, s, k;
      logic [31:0] q, sum, ip;
      n   = slots_in_use();
      s   = write_slot % n;
      q   = '0;
      sum = '0;
      if (mode_reg == MODE_BLEND) begin
        // oldest slot first, each newer slot averaged in with truncation
        q = stored(s, pix) << FRAC_W;
        for (k = 1; k < n; k++) q = (q + (stored((s + k) % n, pix) << FRAC_W)) >> 1;
      end else if (mode_reg == MODE_HALVE) begin
        // newest slot weighs 1/2, the one before 1/4, and so on
        for (k = 0; k < n; k++) q += (stored((s + n - 1 - k) % n, pix) << FRAC_W) >> (k + 1);
      end else begin
        // equal weight over slots 0..n-1; the unused mode lands here too
        for (k = 0; k < n; k++) sum += stored(k, pix);
        q = (sum << FRAC_W) / n;
      end
      ip = q >> FRAC_W;
      if (q[FRAC_W-1:0] > HALF || (q[FRAC_W-1:0] == HALF && ip[0])) ip++;
      if (ip > 255) ip = 255;
      return ip[PIX_VAL_W-1:0];
    endfunction

    function void note_beat(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix,
                            logic [PIX_VAL_W-1:0] val, logic eof);
      int unsigned n, s;
      average_t    want;
      n = slots_in_use();
      s = write_slot % n;
      case (op)
        OP_ADD: begin
          pixels[s*PIXELS + pix] = val;
          if (eof) write_slot = SLOT_W'((s + 1) % n);
          adds++;
        end
        OP_READ: begin
          want.out_index     = pix;
          want.average_value = weighted_average(pix);
          pending_averages.push_back(want);
        end
        OP_CLEAR: begin
          foreach (pixels[i]) pixels[i] = '0;
          write_slot = '0;
          clears++;
        end
        default: unused_beats++;
      endcase
    endfunction

    function void check_beat(logic [PIX_W-1:0] idx, logic [PIX_VAL_W-1:0] avg);
      average_t want;
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected result beat, index %0d average %0d", $time, idx, avg);
        mismatches++;
        return;
      end
      want = pending_averages.pop_front();
      averages_checked++;
      if (idx !== want.out_index) begin
        $display("%0t: out_index expected %0d actual %0d", $time, want.out_index, idx);
        mismatches++;
      end
      if (avg !== want.average_value) begin
        $display("%0t: average_value at index %0d expected %0d actual %0d",
                 $time, want.out_index, want.average_value, avg);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           tx_idle_pct;
  int unsigned           rx_stall_pct;
  logic [PIX_W-1:0]      hot_pix [HOT_N];
  ring_average_tracker   book = new();

  tfar_in_if  in_ch ();
  tfar_out_if out_ch ();

  temporal_frame_average_ring dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: roll ready at every falling edge so stalls land on every phase of a read.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Sample the result channel at the rising edge, before the block updates it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_beat(out_ch.out_index, out_ch.average_value);
  end

  // Hard stop: far beyond the slowest correct run, clearing sweeps included.
  initial begin
    #(CLK_PERIOD * 64'd3_000_000);
    $display("%0t: timeout with %0d averages outstanding", $time, book.pending_averages.size());
    $display("tb_temporal_frame_average_ring failed");
    $finish;
  end

  function automatic void set_idling(input int unsigned style);
    case (style)
      1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
      3: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
    endcase
  endfunction

  // Mostly the hot pixels, so reads land on positions written across several slots.
  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(99) < 85) return hot_pix[$urandom_range(HOT_N - 1)];
    return PIX_W'($urandom);
  endfunction

  function automatic logic [PIX_VAL_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_VAL_W'($urandom);
    endcase
  endfunction

  // Write one register; only called while no input beat is offered and no average is owed.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_register(idx, data);
  endtask

  // Drive one input beat, idling first at random, and hold it until the block takes it.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                           input logic [PIX_VAL_W-1:0] val, input logic eof);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.pixel_index  <= pix;
    in_ch.pixel_value  <= val;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
    book.note_beat(op, pix, val, eof);
  endtask

  // Drop valid, wait for every owed average and for the block to open its input again
  // (a trailing clear sweeps the store first), then let any trailing beat finish.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.pending_averages.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ch.ready);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned counted, burst, k;
    counted = 0;
    while (counted < quota) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          // one frame of adds, mostly over the hot pixels; end of frame on the last beat
          burst = $urandom_range(HOT_N, 1);
          for (k = 1; k <= burst; k++) send_beat(OP_ADD, pick_pixel(), pick_sample(), k == burst);
          counted += burst;
        end
        6, 7, 8: begin
          // read back; end of frame is random here and must be ignored
          burst = $urandom_range(6, 1);
          for (k = 0; k < burst; k++)
            send_beat(OP_READ, pick_pixel(), PIX_VAL_W'($urandom), 1'($urandom_range(1)));
          counted += burst;
        end
        default: begin
          // noise: unused opcode, a stray add, or now and then a clear
          k = $urandom_range(9);
          if (k < 5) begin
            send_beat(OP_UNUSED, PIX_W'($urandom), PIX_VAL_W'($urandom), 1'($urandom_range(1)));
          end else begin
            send_beat(k == 9 ? OP_CLEAR : OP_ADD, PIX_W'($urandom), pick_sample(),
                      1'($urandom_range(1)));
            counted++;
          end
        end
      endcase
    end
  endtask

  initial begin
    int unsigned ph;
    logic [CFG_FRAMES_W-1:0] frames_val;
    logic [CFG_MODE_W-1:0]   mode_val;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_IDX_FRAMES;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_ADD;
    in_ch.pixel_index  = '0;
    in_ch.pixel_value  = '0;
    in_ch.end_of_frame = 1'b0;
    hot_pix[0] = '0;
    hot_pix[1] = '1;
    for (int i = 2; i < HOT_N; i++) hot_pix[i] = PIX_W'($urandom);
    set_idling(0);

    // Hold reset, then release it at a falling edge; the block sweeps its store with ready low.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    write_reg(CFG_IDX_FRAMES, FRAMES_RESET);
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(MODE_EQUAL));
    // Fill the top pixel with full scale in every slot; the ring wraps back to slot 0.
    repeat (FRAMES) send_beat(OP_ADD, '1, '1, 1'b1);
    // End of frame on a read is ignored; pixel 0 was never written.
    send_beat(OP_READ, '1, '0, 1'b1);
    send_beat(OP_READ, '0, '1, 1'b0);
    send_beat(OP_UNUSED, '1, '1, 1'b1);
    send_beat(OP_ADD, '0, 8'd4, 1'b1);
    send_beat(OP_ADD, '0, 8'd1, 1'b1);
    send_beat(OP_READ, '0, '0, 1'b0);
    // Slot count above the ring size, mode code with no meaning, upper data bits set.
    settle();
    write_reg(CFG_IDX_FRAMES, '1);
    write_reg(CFG_IDX_MODE, {2'b11, MODE_UNUSED});
    send_beat(OP_READ, '0, '0, 1'b0);
    send_beat(OP_READ, '1, '0, 1'b0);
    // A slot count of zero acts as one.
    settle();
    write_reg(CFG_IDX_FRAMES, '0);
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(MODE_BLEND));
    send_beat(OP_READ, '0, '0, 1'b0);
    // Shrink the ring to three slots and read in halving mode.
    settle();
    write_reg(CFG_IDX_FRAMES, CFG_DATA_W'(3));
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(MODE_HALVE));
    send_beat(OP_READ, '0, '0, 1'b0);
    send_beat(OP_ADD, '0, 8'd200, 1'b1);
    send_beat(OP_READ, '0, '0, 1'b0);
    // Clear keeps the registers and ignores end of frame.
    send_beat(OP_CLEAR, 14'h2AAA, 8'h55, 1'b1);
    send_beat(OP_ADD, '1, 8'd9, 1'b0);
    send_beat(OP_READ, '1, '0, 1'b0);
    // Blend of 7 and 8 lands exactly on 7.5 and rounds up to the even 8.
    settle();
    write_reg(CFG_IDX_FRAMES, CFG_DATA_W'(2));
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(MODE_BLEND));
    send_beat(OP_ADD, 14'd5, 8'd7, 1'b1);
    send_beat(OP_ADD, 14'd5, 8'd8, 1'b1);
    send_beat(OP_READ, 14'd5, '0, 1'b0);
    settle();

    // ---- random part: one register setting and one idling style per phase ----
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin frames_val = CFG_FRAMES_W'(8);  mode_val = MODE_EQUAL;  end
        1: begin frames_val = CFG_FRAMES_W'(1);  mode_val = MODE_BLEND;  end
        2: begin frames_val = CFG_FRAMES_W'(15); mode_val = MODE_HALVE;  end
        3: begin frames_val = CFG_FRAMES_W'(0);  mode_val = MODE_UNUSED; end
        4: begin frames_val = CFG_FRAMES_W'(3);  mode_val = MODE_BLEND;  end
        5: begin frames_val = CFG_FRAMES_W'(5);  mode_val = MODE_HALVE;  end
        6: begin frames_val = CFG_FRAMES_W'(8);  mode_val = MODE_BLEND;  end
        default: begin
          frames_val = CFG_FRAMES_W'($urandom);
          mode_val   = CFG_MODE_W'($urandom);
        end
      endcase
      write_reg(CFG_IDX_FRAMES, frames_val);
      write_reg(CFG_IDX_MODE, {(CFG_DATA_W - CFG_MODE_W)'($urandom), mode_val});
      set_idling(ph % 4);
      random_phase(PHASE_BEATS);
      settle();
    end

    $display("covered %0d adds, %0d clears, %0d unused-opcode beats, %0d averages checked",
             book.adds, book.clears, book.unused_beats, book.averages_checked);
    $display("across %0d register writes and four idling styles, %0d mismatches",
             book.reg_writes, book.mismatches);
    if (book.mismatches == 0) begin
      $display("tb_temporal_frame_average_ring passed");
    end else begin
      $display("tb_temporal_frame_average_ring failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
